@@ design/kct_pkg.sv @@
// Shared types and constants for the keypad countdown timer.
// Used by the front decoder, the operation queue, the back end and the top level.
package kct_pkg;

  // Count limits and reset values.
  localparam logic [5:0] TIME_MAX      = 6'd59;
  localparam logic [5:0] RESET_MINUTES = 6'd0;
  localparam logic [5:0] RESET_SECONDS = 6'd10;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Keypad column patterns with exactly one low line.
  localparam logic [3:0] COL0_LOW = 4'he;
  localparam logic [3:0] COL1_LOW = 4'hd;
  localparam logic [3:0] COL2_LOW = 4'hb;
  localparam logic [3:0] COL3_LOW = 4'h7;

  // Keypad rows.
  localparam logic [1:0] ROW0 = 2'd0;
  localparam logic [1:0] ROW1 = 2'd1;
  localparam logic [1:0] ROW2 = 2'd2;
  localparam logic [1:0] ROW3 = 2'd3;

  // Command codes on the input channel.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  // Classified operation handed from the front to the back.
  typedef enum logic [3:0] {
    OP_TICK,
    OP_NOKEY,
    OP_DIGIT,
    OP_PAUSE,
    OP_SET,
    OP_RUN,
    OP_TOGGLE,
    OP_UP,
    OP_DOWN
  } kct_op_e_t;

  typedef struct packed {
    logic      valid;
    kct_op_e_t op;
  } kct_req_t;

endpackage

@@ design/keypad_countdown_timer.sv @@
// Keypad countdown timer: a minutes:seconds count driven by ticks and keypad rows.
// Input request: a one-second tick (in_command 0) or one row reading (in_command 1,
// in_key_row, active-low in_key_cols). Each accepted request yields one result:
// the live count, the run, setting, field and buzzer flags after it, and whether
// the reading was a key and whether the seconds prescaler must restart.
// A request is taken when in_valid is high and in_stall low; a result is taken
// when out_valid is high and out_stall low.
// A request accepted at a clock edge is written into the queue, and the back end
// registers its result from the queue head; one request is taken every cycle
// while the receiver does not stall. The rate is set by the back end, which updates
// the state registers once per cycle, and the two-entry queue in front of it.
// When the receiver stalls, the result holds, the back end pauses, the queue
// fills, and in_stall rises once the queue is full.
// Reset (rst_n low, synchronous) empties the queue, drops out_valid and loads
// 00:10 into both the live count and the preset, paused, in setting mode,
// minutes selected, buzzer off.
module keypad_countdown_timer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_command,
  input  logic [1:0] in_key_row,
  input  logic [3:0] in_key_cols,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_minutes,
  output logic [5:0] out_seconds,
  output logic       out_running,
  output logic       out_setting,
  output logic       out_edit_seconds,
  output logic       out_buzzer,
  output logic       out_restart_second,
  output logic       out_key_valid
);
  import kct_pkg::*;

  kct_req_t push_req;
  kct_req_t head;
  logic     q_full;
  logic     q_pop;

  // Classify the incoming request.
  kct_front u_front (
    .cmd_valid (in_valid),
    .command   (in_command),
    .key_row   (in_key_row),
    .key_cols  (in_key_cols),
    .req       (push_req)
  );

  // Queue between classification and execution.
  kct_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_req (push_req),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head)
  );

  assign in_stall = q_full;

  // Execute operations and present results.
  kct_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_minutes        (out_minutes),
    .out_seconds        (out_seconds),
    .out_running        (out_running),
    .out_setting        (out_setting),
    .out_edit_seconds   (out_edit_seconds),
    .out_buzzer         (out_buzzer),
    .out_restart_second (out_restart_second),
    .out_key_valid      (out_key_valid)
  );

endmodule

@@ design/kct_front.sv @@
// Front end: classifies each accepted request into one timer operation.
// Depends on kct_pkg for the operation codes and keypad constants.
module kct_front (
  input  logic             cmd_valid,
  input  logic             command,
  input  logic [1:0]       key_row,
  input  logic [3:0]       key_cols,
  output kct_pkg::kct_req_t req
);
  import kct_pkg::*;

  logic [1:0] col;
  logic       col_ok;

  // Find the single low column, if there is one.
  always_comb begin
    col    = 2'd0;
    col_ok = 1'b1;
    unique case (key_cols)
      COL0_LOW: col = 2'd0;
      COL1_LOW: col = 2'd1;
      COL2_LOW: col = 2'd2;
      COL3_LOW: col = 2'd3;
      default:  col_ok = 1'b0;
    endcase
  end

  // Map the row and column to an operation.
  always_comb begin
    req.valid = cmd_valid;
    req.op    = OP_DIGIT;
    if (command == CMD_TICK) begin
      req.op = OP_TICK;
    end else if (!col_ok) begin
      req.op = OP_NOKEY;
    end else if (col == 2'd3) begin
      unique case (key_row)
        ROW0:    req.op = OP_RUN;
        ROW1:    req.op = OP_SET;
        ROW2:    req.op = OP_UP;
        ROW3:    req.op = OP_DOWN;
        default: req.op = OP_DIGIT;
      endcase
    end else if (key_row == ROW3) begin
      // Bottom row: star, zero, pound.
      unique case (col)
        2'd1:    req.op = OP_PAUSE;
        default: req.op = OP_TOGGLE;
      endcase
    end else begin
      req.op = OP_DIGIT;
    end
  end

endmodule

@@ design/kct_queue.sv @@
// Short queue of classified operations between the front and the back.
// Depends on kct_pkg for the request type and the queue depth.
module kct_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  kct_pkg::kct_req_t  push_req,
  output logic               full,
  input  logic               pop,
  output kct_pkg::kct_req_t  head
);
  import kct_pkg::*;

  kct_op_e_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic                do_push;
  logic                do_pop;

  localparam logic [QPTR_W-1:0] PTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
  localparam logic [QCNT_W-1:0] CNT_FULL = QCNT_W'(QUEUE_DEPTH);

  assign full       = (count_r == CNT_FULL);
  assign do_push    = push_req.valid && !full;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = (count_r != '0);
  assign head.op    = mem_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_req.op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ design/kct_back.sv @@
// Back end: holds the timer state, carries out operations and registers results.
// Depends on kct_pkg for operation codes and count constants.
module kct_back (
  input  logic              clk,
  input  logic              rst_n,
  input  kct_pkg::kct_req_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [5:0]        out_minutes,
  output logic [5:0]        out_seconds,
  output logic              out_running,
  output logic              out_setting,
  output logic              out_edit_seconds,
  output logic              out_buzzer,
  output logic              out_restart_second,
  output logic              out_key_valid
);
  import kct_pkg::*;

  logic [5:0] live_min_r, live_min_nxt;
  logic [5:0] live_sec_r, live_sec_nxt;
  logic [5:0] pre_min_r, pre_min_nxt;
  logic [5:0] pre_sec_r, pre_sec_nxt;
  logic       run_r, run_nxt;
  logic       set_r, set_nxt;
  logic       field_r, field_nxt;
  logic       buzz_r, buzz_nxt;
  logic       restart_nxt;
  logic       key_nxt;
  logic       editable;

  logic       out_valid_r;
  logic       restart_r;
  logic       key_r;

  function automatic logic [5:0] step_up(input logic [5:0] v);
    return (v < TIME_MAX) ? v + 6'd1 : 6'd0;
  endfunction

  function automatic logic [5:0] step_down(input logic [5:0] v);
    return (v != 6'd0) ? v - 6'd1 : TIME_MAX;
  endfunction

  // Take the next operation when the result register is free or being drained.
  assign pop = head.valid && (!out_valid_r || !out_stall);

  assign editable = !run_r || set_r;

  // Next timer state for the operation at the head of the queue.
  always_comb begin
    live_min_nxt = live_min_r;
    live_sec_nxt = live_sec_r;
    pre_min_nxt  = pre_min_r;
    pre_sec_nxt  = pre_sec_r;
    run_nxt      = run_r;
    set_nxt      = set_r;
    field_nxt    = field_r;
    buzz_nxt     = buzz_r;
    restart_nxt  = 1'b0;
    key_nxt      = 1'b0;
    unique case (head.op)
      OP_TICK: begin
        if (run_r) begin
          if (live_sec_r != 6'd0) begin
            live_sec_nxt = live_sec_r - 6'd1;
          end else if (live_min_r != 6'd0) begin
            live_min_nxt = live_min_r - 6'd1;
            live_sec_nxt = TIME_MAX;
          end else begin
            buzz_nxt = !buzz_r;
          end
        end
      end
      OP_NOKEY: begin
      end
      OP_DIGIT: key_nxt = 1'b1;
      OP_PAUSE: begin
        key_nxt = 1'b1;
        run_nxt = 1'b0;
      end
      OP_SET: begin
        key_nxt = 1'b1;
        run_nxt = 1'b0;
        set_nxt = 1'b1;
      end
      OP_RUN: begin
        key_nxt = 1'b1;
        run_nxt = 1'b1;
        set_nxt = 1'b0;
      end
      OP_TOGGLE: begin
        key_nxt = 1'b1;
        if (editable) field_nxt = !field_r;
      end
      OP_UP: begin
        key_nxt = 1'b1;
        if (editable) begin
          if (field_r) pre_sec_nxt = step_up(pre_sec_r);
          else pre_min_nxt = step_up(pre_min_r);
        end
      end
      OP_DOWN: begin
        key_nxt = 1'b1;
        if (editable) begin
          if (field_r) pre_sec_nxt = step_down(pre_sec_r);
          else pre_min_nxt = step_down(pre_min_r);
        end
      end
      default: begin
      end
    endcase
    // Any key that leaves the timer in setting mode reloads the live count from the preset.
    if (key_nxt && set_nxt) begin
      live_min_nxt = pre_min_nxt;
      live_sec_nxt = pre_sec_nxt;
      buzz_nxt     = 1'b0;
      restart_nxt  = 1'b1;
    end
  end

  // Timer state and result flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_min_r  <= RESET_MINUTES;
      live_sec_r  <= RESET_SECONDS;
      pre_min_r   <= RESET_MINUTES;
      pre_sec_r   <= RESET_SECONDS;
      run_r       <= 1'b0;
      set_r       <= 1'b1;
      field_r     <= 1'b0;
      buzz_r      <= 1'b0;
      out_valid_r <= 1'b0;
      restart_r   <= 1'b0;
      key_r       <= 1'b0;
    end else begin
      if (pop) begin
        live_min_r <= live_min_nxt;
        live_sec_r <= live_sec_nxt;
        pre_min_r  <= pre_min_nxt;
        pre_sec_r  <= pre_sec_nxt;
        run_r      <= run_nxt;
        set_r      <= set_nxt;
        field_r    <= field_nxt;
        buzz_r     <= buzz_nxt;
        restart_r  <= restart_nxt;
        key_r      <= key_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The state registers double as the result register.
  assign out_valid          = out_valid_r;
  assign out_minutes        = live_min_r;
  assign out_seconds        = live_sec_r;
  assign out_running        = run_r;
  assign out_setting        = set_r;
  assign out_edit_seconds   = field_r;
  assign out_buzzer         = buzz_r;
  assign out_restart_second = restart_r;
  assign out_key_valid      = key_r;

endmodule
